FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the matcher RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CNPM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cnpm: same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define CNPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cnpm: next-cycle implication failed");

`endif

FILE: rtl/core/cnpm_pkg.sv
// ----------------------------------------------------------------------------
// cnpm_pkg
// Types, constants and width helpers for the cosine nearest-prototype matcher.
// ----------------------------------------------------------------------------
package cnpm_pkg;

   localparam int VALUE_WIDTH         = 16;
   localparam int CLASS_WIDTH         = 4;
   localparam int ELEMENT_WIDTH       = 7;
   localparam int SIM_WIDTH           = 16;
   localparam int FRAC_SHIFT          = 15;
   localparam int MAX_CLASSES_DEFAULT = 16;
   localparam int EMBED_DIM_DEFAULT   = 128;

   localparam logic signed [SIM_WIDTH-1:0] THRESHOLD_RESET = 16'sd19661;
   localparam logic signed [SIM_WIDTH-1:0] SIM_POS_MAX     = 16'sd32767;
   localparam logic signed [SIM_WIDTH-1:0] SIM_NEG_MAX     = -16'sd32768;

   localparam logic OP_PROTO_WRITE = 1'b0;
   localparam logic OP_QUERY       = 1'b1;

   typedef struct packed {
      logic                           operation;
      logic [CLASS_WIDTH-1:0]         class_index;
      logic [ELEMENT_WIDTH-1:0]       element_index;
      logic signed [VALUE_WIDTH-1:0]  element_value;
      logic                           last;
   } req_payload_type;

   typedef struct packed {
      logic                           match_found;
      logic [CLASS_WIDTH-1:0]         best_class;
      logic signed [SIM_WIDTH-1:0]    best_similarity;
      logic                           query_overflow;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic take_req;
      logic scan_init;
      logic dot_init;
      logic issue;
      logic mul_init;
      logic mul_step;
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic best_update;
      logic class_next;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_go;
      logic class_eligible;
      logic all_issued;
      logic pipe_empty;
      logic norm_zero;
      logic last_class;
      logic rsp_free;
   } status_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // width of a sum of squares over dim elements
   function automatic int norm_width(input int dim);
      return 2 * VALUE_WIDTH + $clog2(dim);
   endfunction

endpackage

FILE: rtl/core/cnpm_stream_if.sv
// ----------------------------------------------------------------------------
// cnpm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface cnpm_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/cnpm_ram.sv
// ----------------------------------------------------------------------------
// cnpm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cnpm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   write_enable,
   input  logic [cnpm_pkg::addr_width(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]                       write_data,
   input  logic [cnpm_pkg::addr_width(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]                       read_data
);
   import cnpm_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;
endmodule

FILE: rtl/core/cnpm_ctrl.sv
// ----------------------------------------------------------------------------
// cnpm_ctrl
// Sequencer for intake, per-class dot product, product, root and divide.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnpm_ctrl #(
   parameter int EMBED_DIM = cnpm_pkg::EMBED_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cnpm_pkg::status_type st,
   output cnpm_pkg::cmd_type    cmd
);
   import cnpm_pkg::*;

   localparam int NW = norm_width(EMBED_DIM);
   localparam int QW = NW + 1 + FRAC_SHIFT;
   localparam int SW = $clog2(QW + 1);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CHECK  = 9'b000000010,
      ST_DOT    = 9'b000000100,
      ST_MUL    = 9'b000001000,
      ST_SQRT   = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_BEST   = 9'b001000000,
      ST_NEXT   = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_req = 1'b1;
            if (st.scan_go) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (st.class_eligible) begin
               cmd.dot_init = 1'b1;
               state_in     = ST_DOT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DOT: begin
            if (!st.all_issued) begin
               cmd.issue = 1'b1;
            end else if (st.pipe_empty) begin
               step_in  = '0;
               state_in = st.norm_zero ? ST_NEXT : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_init = (step_ff == '0);
            cmd.mul_step = (step_ff != '0);
            if (step_ff == SW'(NW)) begin
               step_in  = '0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_init = (step_ff == '0);
            cmd.sqrt_step = (step_ff != '0);
            if (step_ff == SW'(NW)) begin
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_init = (step_ff == '0);
            cmd.div_step = (step_ff != '0);
            if (step_ff == SW'(QW)) begin
               step_in  = '0;
               state_in = ST_BEST;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_BEST: begin
            cmd.best_update = 1'b1;
            state_in        = ST_NEXT;
         end
         ST_NEXT: begin
            if (st.last_class) begin
               state_in = ST_FINISH;
            end else begin
               cmd.class_next = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (st.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `CNPM_ASSERT_NEXT(a_scan_enters_check, clock, reset,
      st.scan_go && state_ff == ST_IDLE, state_ff == ST_CHECK)
   `CNPM_ASSERT_IMPLIES(a_step_bounded, clock, reset,
      state_ff == ST_MUL || state_ff == ST_SQRT, step_ff <= SW'(NW))
   `CNPM_ASSERT_IMPLIES(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
endmodule

FILE: rtl/core/cnpm_dp.sv
// ----------------------------------------------------------------------------
// cnpm_dp
// Prototype and query storage, multiply-accumulate, serial product, root,
// divider, best tracking, threshold register and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnpm_dp #(
   parameter int MAX_CLASSES = cnpm_pkg::MAX_CLASSES_DEFAULT,
   parameter int EMBED_DIM   = cnpm_pkg::EMBED_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cnpm_pkg::cmd_type                   cmd,
   output cnpm_pkg::status_type                st,
   input  logic                                req_valid,
   input  cnpm_pkg::req_payload_type           req_payload,
   output logic                                req_ready,
   output logic                                rsp_valid,
   output cnpm_pkg::rsp_payload_type           rsp_payload,
   input  logic                                rsp_ready,
   input  logic                                csr_write_enable,
   input  logic [cnpm_pkg::VALUE_WIDTH-1:0]    csr_write_data
);
   import cnpm_pkg::*;

   localparam int CW     = addr_width(MAX_CLASSES);
   localparam int LW     = $clog2(EMBED_DIM + 1);
   localparam int QAW    = addr_width(EMBED_DIM);
   localparam int PDEPTH = MAX_CLASSES * EMBED_DIM;
   localparam int PAW    = addr_width(PDEPTH);
   localparam int PW     = 2 * VALUE_WIDTH;
   localparam int NW     = norm_width(EMBED_DIM);
   localparam int DW     = NW + 1;
   localparam int QW     = DW + FRAC_SHIFT;
   localparam logic [QW-1:0] SAT_NEG = QW'(32768);
   localparam logic [QW-1:0] SAT_POS = QW'(32767);

   // intake
   logic accept, is_query, proto_we, query_we;
   logic [PAW-1:0] proto_waddr, proto_raddr;
   logic [VALUE_WIDTH-1:0] proto_rdata, query_rdata;

   logic [LW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          valid_ff [MAX_CLASSES];
   logic [LW-1:0] length_ff [MAX_CLASSES];

   // scan
   logic [CW-1:0] cls_ff, cls_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic          rd_v_ff, rd_v_in, prod_v_ff, prod_v_in;
   logic signed [PW-1:0] prod_dot_ff, prod_dot_in, prod_qq_ff, prod_qq_in;
   logic signed [PW-1:0] prod_pp_ff, prod_pp_in;
   logic signed [DW-1:0] dot_ff, dot_in;
   logic [NW-1:0]        na_ff, na_in, nb_ff, nb_in;

   // serial product, root, divide
   logic [2*NW-1:0] mcand_ff, mcand_in, prod_ff, prod_in;
   logic [NW-1:0]   mplier_ff, mplier_in;
   logic [2*NW-1:0] num_ff, num_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [NW-1:0]   rem_ff, rem_in, root;
   logic [NW:0]     rem_sh;
   logic            rem_ge;
   logic [DW-1:0]   dot_mag;
   logic            dot_neg;

   logic signed [SIM_WIDTH-1:0] sim, best_ff, best_in, thr_ff, thr_in;
   logic [CLASS_WIDTH-1:0]      best_cls_ff, best_cls_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_payload_type             rsp_ff, rsp_in;

   assign req_ready   = cmd.take_req;
   assign accept      = cmd.take_req && req_valid;
   assign is_query    = (req_payload.operation == OP_QUERY);
   assign proto_we    = accept && (req_payload.operation == OP_PROTO_WRITE)
                        && (32'(req_payload.class_index) < MAX_CLASSES)
                        && (32'(req_payload.element_index) < EMBED_DIM);
   assign query_we    = accept && is_query && (count_ff < LW'(EMBED_DIM));
   assign proto_waddr = PAW'(req_payload.class_index) * PAW'(EMBED_DIM)
                        + PAW'(req_payload.element_index);
   assign proto_raddr = PAW'(cls_ff) * PAW'(EMBED_DIM) + PAW'(idx_ff);

   cnpm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(PDEPTH)) u_proto_ram (
      .clock        (clock),
      .write_enable (proto_we),
      .write_address(proto_waddr),
      .write_data   (req_payload.element_value),
      .read_address (proto_raddr),
      .read_data    (proto_rdata)
   );

   cnpm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(EMBED_DIM)) u_query_ram (
      .clock        (clock),
      .write_enable (query_we),
      .write_address(count_ff[QAW-1:0]),
      .write_data   (req_payload.element_value),
      .read_address (idx_ff[QAW-1:0]),
      .read_data    (query_rdata)
   );

   // class tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CLASSES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (proto_we && req_payload.last) begin
         valid_ff[CW'(req_payload.class_index)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (proto_we && req_payload.last) begin
         length_ff[CW'(req_payload.class_index)] <= LW'(req_payload.element_index) + 1'b1;
      end
   end

   // similarity of the current class
   assign dot_neg = dot_ff[DW-1];
   assign dot_mag = dot_neg ? DW'(-dot_ff) : DW'(dot_ff);
   assign root    = res_ff[NW-1:0];
   assign trial   = res_ff + bit_ff;
   assign rem_sh  = {rem_ff, quo_ff[QW-1]};
   assign rem_ge  = rem_sh >= {1'b0, root};

   always_comb begin
      if (dot_neg) begin
         sim = (quo_ff >= SAT_NEG) ? SIM_NEG_MAX
                                   : $signed(SIM_WIDTH'(16'd0 - quo_ff[SIM_WIDTH-1:0]));
      end else begin
         sim = (quo_ff >= SAT_POS) ? SIM_POS_MAX : $signed(quo_ff[SIM_WIDTH-1:0]);
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      cls_in       = cls_ff;
      idx_in       = idx_ff;
      rd_v_in      = cmd.issue;
      prod_v_in    = rd_v_ff;
      prod_dot_in  = $signed(query_rdata) * $signed(proto_rdata);
      prod_qq_in   = $signed(query_rdata) * $signed(query_rdata);
      prod_pp_in   = $signed(proto_rdata) * $signed(proto_rdata);
      dot_in       = dot_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      best_in      = best_ff;
      best_cls_in  = best_cls_ff;
      thr_in       = csr_write_enable ? $signed(csr_write_data) : thr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (query_we) begin
         count_in = count_ff + 1'b1;
      end else if (accept && is_query) begin
         // drop elements past the dimension
         ovf_in = 1'b1;
      end

      if (cmd.scan_init) begin
         cls_in      = '0;
         best_in     = '0;
         best_cls_in = '0;
      end else if (cmd.class_next) begin
         cls_in = cls_ff + 1'b1;
      end

      if (cmd.dot_init) begin
         idx_in = '0;
         dot_in = '0;
         na_in  = '0;
         nb_in  = '0;
      end else begin
         if (cmd.issue) begin
            idx_in = idx_ff + 1'b1;
         end
         if (prod_v_ff) begin
            dot_in = dot_ff + DW'(prod_dot_ff);
            na_in  = na_ff + NW'($unsigned(prod_qq_ff));
            nb_in  = nb_ff + NW'($unsigned(prod_pp_ff));
         end
      end

      if (cmd.mul_init) begin
         mcand_in  = (2*NW)'(na_ff);
         mplier_in = nb_ff;
         prod_in   = '0;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end

      if (cmd.sqrt_init) begin
         num_in = prod_ff;
         res_in = '0;
         bit_in = {2'b01, {(2*NW-2){1'b0}}};
      end else if (cmd.sqrt_step) begin
         if (num_ff >= trial) begin
            num_in = num_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      if (cmd.div_init) begin
         quo_in = QW'(dot_mag) << FRAC_SHIFT;
         rem_in = '0;
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? NW'(rem_sh - {1'b0, root}) : NW'(rem_sh);
         quo_in = {quo_ff[QW-2:0], rem_ge};
      end

      if (cmd.best_update && (sim > best_ff)) begin
         best_in     = sim;
         best_cls_in = CLASS_WIDTH'(cls_ff);
      end

      if (cmd.finish) begin
         rsp_valid_in           = 1'b1;
         rsp_in.match_found     = (best_ff > 0) && (best_ff >= thr_ff);
         rsp_in.best_class      = best_cls_ff;
         rsp_in.best_similarity = best_ff;
         rsp_in.query_overflow  = ovf_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESHOLD_RESET;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff      <= cls_in;
      idx_ff      <= idx_in;
      prod_dot_ff <= prod_dot_in;
      prod_qq_ff  <= prod_qq_in;
      prod_pp_ff  <= prod_pp_in;
      dot_ff      <= dot_in;
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      best_ff     <= best_in;
      best_cls_ff <= best_cls_in;
      rsp_ff      <= rsp_in;
   end

   assign st.scan_go        = accept && is_query && req_payload.last;
   assign st.class_eligible = valid_ff[cls_ff] && (length_ff[cls_ff] == count_ff);
   assign st.all_issued     = (idx_ff == count_ff);
   assign st.pipe_empty     = !rd_v_ff && !prod_v_ff;
   assign st.norm_zero      = (na_ff == '0) || (nb_ff == '0);
   assign st.last_class     = (cls_ff == CW'(MAX_CLASSES - 1));
   assign st.rsp_free       = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CNPM_ASSERT_NEXT(a_count_advances, clock, reset,
      query_we && !cmd.finish, count_ff == $past(count_ff) + 1'b1)
   `CNPM_ASSERT_IMPLIES(a_result_not_overwritten, clock, reset,
      cmd.finish, !rsp_valid_ff || rsp_ready)
   `CNPM_ASSERT_IMPLIES(a_count_bounded, clock, reset, 1'b1, count_ff <= LW'(EMBED_DIM))
endmodule

FILE: rtl/core/cosine_nearest_prototype_match.sv
// ----------------------------------------------------------------------------
// cosine_nearest_prototype_match
// Nearest-prototype search by cosine similarity over stored class vectors.
//
//   channel   | dir | transaction
//   ----------+-----+----------------------------------------------------
//   req_if    | in  | prototype element write or query element
//   rsp_if    | out | match_found, best_class, best_similarity, overflow
//   csr_*     | in  | match_threshold write, no read-back
//
// A prototype write or a non-final query element is accepted while idle. A final
// query element scans all classes, skipping ineligible ones; an eligible
// class runs the multiply and root units over NW = 39 bits and the divider
// over QW = 55 bits by default, each unit one bit per cycle.
// Reset is synchronous and clears the class valid bits and the query state.
// A pending result holds the search in its final state and stalls the intake
// until the result is taken.
// ----------------------------------------------------------------------------
module cosine_nearest_prototype_match #(
   parameter int MAX_CLASSES = cnpm_pkg::MAX_CLASSES_DEFAULT,
   parameter int EMBED_DIM   = cnpm_pkg::EMBED_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   cnpm_stream_if.sink                      req_if,
   cnpm_stream_if.source                    rsp_if,
   input  logic                             csr_write_enable,
   input  logic [cnpm_pkg::VALUE_WIDTH-1:0] csr_write_data
);
   import cnpm_pkg::*;

   cmd_type         cmd;
   status_type      st;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready, rsp_valid;

   assign req_payload = req_if.payload;

   cnpm_ctrl #(.EMBED_DIM(EMBED_DIM)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .st   (st),
      .cmd  (cmd)
   );

   cnpm_dp #(.MAX_CLASSES(MAX_CLASSES), .EMBED_DIM(EMBED_DIM)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_valid       (req_if.valid),
      .req_payload     (req_payload),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_payload     (rsp_payload),
      .rsp_ready       (rsp_if.ready),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_payload;
endmodule

FILE: bench/tb_cosine_nearest_prototype_match.sv
// ----------------------------------------------------------------------------
// tb_cosine_nearest_prototype_match
// Self-checking bench for the cosine nearest-prototype matcher: writes class
// prototypes, sends queries and checks each search result against a
// bit-accurate predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_cosine_nearest_prototype_match;
   import cnpm_pkg::*;

   localparam int NUM_CLASSES  = MAX_CLASSES_DEFAULT;
   localparam int DIM          = EMBED_DIM_DEFAULT;
   localparam int STALL_LIMIT  = 40000;
   localparam int LONG_HOLD    = 3000;
   localparam int SETTLE_WAIT  = 80;

   typedef struct {
      req_payload_type pl;
      bit              drain_first;
   } pending_item_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [VALUE_WIDTH-1:0] csr_write_data;

   cnpm_stream_if #(.payload_type(req_payload_type)) req_if ();
   cnpm_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   cosine_nearest_prototype_match i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic signed [VALUE_WIDTH-1:0] proto_mem [NUM_CLASSES][DIM];
   int unsigned                   proto_len [NUM_CLASSES];
   bit                            proto_ok  [NUM_CLASSES];
   logic signed [VALUE_WIDTH-1:0] query_mem [DIM];
   int unsigned                   query_len;
   bit                            query_ovf;
   logic signed [SIM_WIDTH-1:0]   threshold_now;

   pending_item_type item_queue [$];
   rsp_payload_type  expected_results [$];

   // generator's view of the table
   int gen_vec   [NUM_CLASSES][DIM];
   int gen_len   [NUM_CLASSES];
   bit gen_valid [NUM_CLASSES];
   bit gen_wrote [NUM_CLASSES][DIM];

   int  error_count;
   int  gap_left;
   int  stall_left;
   int  hold_left;
   bit  sender_idle;
   bit  receiver_idle;
   bit  hold_request;
   bit  hold_done;
   int  quiet_cycles;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic logic signed [SIM_WIDTH-1:0] class_score(input int cls);
      longint          dot, na, nb, a, b;
      bit [127:0]      prod, root, trial, mag, quot;
      bit              neg;
      if (proto_len[cls] != query_len || query_len == 0) return '0;
      dot = 0; na = 0; nb = 0;
      for (int i = 0; i < query_len; i++) begin
         a = query_mem[i];
         b = proto_mem[cls][i];
         dot += a * b;
         na  += a * a;
         nb  += b * b;
      end
      if (na == 0 || nb == 0) return '0;
      prod = 128'(na) * 128'(nb);
      root = '0;
      for (int k = 63; k >= 0; k--) begin
         trial = root | (128'd1 << k);
         if (trial * trial <= prod) root = trial;
      end
      if (root == 0) return '0;
      neg  = dot < 0;
      mag  = neg ? 128'(-dot) : 128'(dot);
      quot = (mag << FRAC_SHIFT) / root;
      if (neg) return (quot >= 32768) ? SIM_NEG_MAX : -SIM_WIDTH'(quot);
      return (quot >= 32767) ? SIM_POS_MAX : SIM_WIDTH'(quot);
   endfunction

   // advance the predictor by one accepted transaction
   task automatic apply_item(input req_payload_type it);
      logic signed [SIM_WIDTH-1:0] best, s;
      int                          best_cls;
      rsp_payload_type             r;
      if (it.operation == OP_PROTO_WRITE) begin
         proto_mem[it.class_index][it.element_index] = it.element_value;
         if (it.last) begin
            proto_len[it.class_index] = it.element_index + 1;
            proto_ok[it.class_index]  = 1'b1;
         end
         return;
      end
      if (query_len < DIM) begin
         query_mem[query_len] = it.element_value;
         query_len++;
      end else begin
         query_ovf = 1'b1;
      end
      if (!it.last) return;
      best = '0;
      best_cls = 0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (proto_ok[c]) begin
            s = class_score(c);
            if (s > best) begin
               best = s;
               best_cls = c;
            end
         end
      end
      r.match_found     = (best > 0) && (best >= threshold_now);
      r.best_class      = CLASS_WIDTH'(best_cls);
      r.best_similarity = best;
      r.query_overflow  = query_ovf;
      expected_results = {expected_results, r};
      query_len = 0;
      query_ovf = 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      logic             next_valid;
      pending_item_type it;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            apply_item(req_if.payload);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (item_queue.size() > 0 &&
                         (!item_queue[0].drain_first || expected_results.size() == 0)) begin
               it = item_queue.pop_front();
               req_if.payload <= it.pl;
               next_valid = 1'b1;
               gap_left = sender_idle ? $urandom_range(0, 9) : 0;
            end
         end
         req_if.valid <= next_valid;
      end
   end

   // monitor
   always @(posedge clock) begin
      logic            next_ready;
      rsp_payload_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, best_class", rsp_if.payload.best_class, -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.payload.match_found !== want.match_found)
                  report_mismatch("match_found", rsp_if.payload.match_found,
                                  want.match_found);
               if (rsp_if.payload.best_class !== want.best_class)
                  report_mismatch("best_class", rsp_if.payload.best_class, want.best_class);
               if (rsp_if.payload.best_similarity !== want.best_similarity)
                  report_mismatch("best_similarity", rsp_if.payload.best_similarity,
                                  want.best_similarity);
               if (rsp_if.payload.query_overflow !== want.query_overflow)
                  report_mismatch("query_overflow", rsp_if.payload.query_overflow,
                                  want.query_overflow);
            end
            stall_left = receiver_idle ? $urandom_range(0, 9) : 0;
         end
         if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_if.ready <= next_ready;
      end
   end

   // watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("cosine_nearest_prototype_match test failed");
            $finish;
         end
      end
   end

   function automatic int clamp16(input int v);
      return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
   endfunction

   function automatic int rand16();
      return int'($signed(16'($urandom_range(0, 65535))));
   endfunction

   task automatic push_item(input logic op, input int cls, input int el, input int val,
                            input bit last, input bit drain = 1'b0);
      pending_item_type it;
      it.pl.operation     = op;
      it.pl.class_index   = CLASS_WIDTH'(cls);
      it.pl.element_index = ELEMENT_WIDTH'(el);
      it.pl.element_value = VALUE_WIDTH'(val);
      it.pl.last          = last;
      it.drain_first      = drain;
      item_queue = {item_queue, it};
   endtask

   // kind: 0 random, 1 zero, 2 extremes, 3 single spike
   task automatic write_proto(input int cls, input int len, input int kind);
      int v;
      for (int e = 0; e < len; e++) begin
         case (kind)
            0: v = rand16();
            1: v = 0;
            2: v = e[0] ? -32768 : 32767;
            default: v = (e == 0) ? 4096 : 0;
         endcase
         gen_vec[cls][e] = v;
         gen_wrote[cls][e] = 1'b1;
         push_item(OP_PROTO_WRITE, cls, e, v, e == len - 1);
      end
      gen_len[cls] = len;
      gen_valid[cls] = 1'b1;
   endtask

   // mode: 0 near copy, 1 exact copy, 2 negated, 3 random
   task automatic send_query(input int len, input int cls, input int mode, input bit drain = 0);
      int v;
      for (int e = 0; e < len; e++) begin
         v = (e < DIM && cls >= 0) ? gen_vec[cls][e] : 0;
         case (mode)
            0: v = clamp16(v + $urandom_range(0, 2047) - 1024);
            1: ;
            2: v = clamp16(-v);
            default: v = rand16();
         endcase
         push_item(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 127), v, e == len - 1,
                   drain && e == 0);
      end
   endtask

   task automatic random_noise_write();
      int  cls, el, v;
      bit  last, complete;
      cls = $urandom_range(0, 15);
      el  = $urandom_range(0, 127);
      v   = rand16();
      last = $urandom_range(0, 1);
      gen_vec[cls][el] = v;
      gen_wrote[cls][el] = 1'b1;
      complete = 1'b1;
      for (int e = 0; e <= el; e++) if (!gen_wrote[cls][e]) complete = 1'b0;
      // a length whose elements were never all written must not be declared
      if (!complete) last = 1'b0;
      if (last) begin
         gen_len[cls] = el + 1;
         gen_valid[cls] = 1'b1;
      end
      push_item(OP_PROTO_WRITE, cls, el, v, last);
   endtask

   task automatic random_phase(input int target);
      int start, cls, len, pick;
      start = item_queue.size();
      while (item_queue.size() - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            len = ($urandom_range(0, 39) == 0) ? DIM : $urandom_range(1, 6);
            write_proto($urandom_range(0, 15), len, $urandom_range(0, 9) == 0 ? 1 : 0);
         end else if (pick < 75) begin
            cls = $urandom_range(0, 15);
            if (gen_valid[cls]) send_query(gen_len[cls], cls, $urandom_range(0, 3));
            else send_query($urandom_range(1, 6), -1, 3);
         end else if (pick < 85) begin
            send_query($urandom_range(1, 8), -1, 3);
         end else if (pick < 87) begin
            send_query($urandom_range(DIM + 1, DIM + 3), -1, 3);
         end else begin
            random_noise_write();
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (item_queue.size() != 0 || req_if.valid || expected_results.size() != 0);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [SIM_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      threshold_now = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic signed [SIM_WIDTH-1:0] settings [5];
      error_count = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      hold_request = 1'b0;
      hold_done = 1'b0;
      threshold_now = THRESHOLD_RESET;
      query_len = 0;
      query_ovf = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         proto_len[c] = 0;
         proto_ok[c] = 1'b0;
         gen_len[c] = 0;
         gen_valid[c] = 1'b0;
         for (int e = 0; e < DIM; e++) begin
            proto_mem[c][e] = '0;
            gen_vec[c][e] = 0;
            gen_wrote[c][e] = 1'b0;
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: no class yet, spike, extremes, zero norm, tie, length mismatch
      send_query(1, -1, 3);
      write_proto(0, 4, 3);
      write_proto(1, 4, 2);
      write_proto(2, 4, 1);
      write_proto(4, 4, 3);
      send_query(4, 0, 1);
      send_query(4, 1, 2);
      send_query(3, 0, 1);
      wait_idle();

      settings[0] = 16'sd0;
      settings[1] = SIM_NEG_MAX;
      settings[2] = SIM_POS_MAX;
      settings[3] = SIM_WIDTH'($urandom_range(0, 32767));
      settings[4] = THRESHOLD_RESET;
      for (int p = 0; p < 5; p++) begin
         write_threshold(settings[p]);
         sender_idle   = (p != 1);
         receiver_idle = (p != 3);
         if (p == 1) begin
            // back up results behind a stalled receiver while queries keep coming
            hold_request = 1'b1;
            send_query(DIM + 2, -1, 3);
         end
         if (p == 2) send_query(gen_len[0], 0, 1, 1'b1);
         random_phase(75);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("cosine_nearest_prototype_match test passed");
      end else begin
         $display("cosine_nearest_prototype_match test failed");
      end
      $finish;
   end

endmodule
